// ===== src/upcm_pkg.sv =====
// ----------------------------------------------------------------------------
// upcm_pkg
// Types, constants and helpers shared by the unique-prefix command matcher.
// ----------------------------------------------------------------------------
package upcm_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int MAX_CHARS   = 11;

    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W       = $clog2(MAX_CHARS + 1);
    localparam int TCHAR_DEPTH = MAX_ENTRIES * MAX_CHARS;
    localparam int TCHAR_AW    = $clog2(TCHAR_DEPTH);

    localparam int CHAR_W      = 8;
    localparam int ECNT_W      = 7;
    localparam int CMP_W       = (ECNT_W > CNT_W) ? ECNT_W : CNT_W;
    localparam int OUT_IDX_W   = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int HITS_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CASE_FOLD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b1;

    localparam logic [HITS_W-1:0] HITS_NONE = 2'd0;
    localparam logic [HITS_W-1:0] HITS_ONE  = 2'd1;
    localparam logic [HITS_W-1:0] HITS_MANY = 2'd2;

    typedef enum logic [1:0] {
        REQ_TABLE_WR = 2'd0,
        REQ_CHAR     = 2'd1,
        REQ_END      = 2'd2,
        REQ_NONE     = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        VERD_OPEN    = 2'd0,
        VERD_LESS    = 2'd1,
        VERD_GREATER = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        MATCH_SINGLE = 2'd0,
        MATCH_NONE   = 2'd1,
        MATCH_AMBIG  = 2'd2
    } match_status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SCAN,
        CS_WALK,
        CS_REPORT
    } ctrl_state_t;

    typedef struct packed {
        req_type_t         req_type;
        logic [5:0]        entry_index;
        logic [3:0]        char_pos;
        logic [CHAR_W-1:0] char_value;
    } in_item_t;

    typedef struct packed {
        match_status_t         match_status;
        logic [OUT_IDX_W-1:0]  match_index;
    } out_item_t;

    typedef struct packed {
        logic tbl_write;
        logic start_char;
        logic start_walk;
        logic load_out;
    } upcm_cmd_t;

    typedef struct packed {
        logic done;
        logic char_nonzero;
        logic out_free;
    } upcm_status_t;

    function automatic logic [CHAR_W-1:0] fold_char(input logic fold,
                                                    input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (fold && c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== src/upcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// upcm_ctrl
// Controller: takes input transactions and sequences table writes, character
// scans, the closing walk and the result hand-off.
// ----------------------------------------------------------------------------
module upcm_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  upcm_pkg::req_type_t    s_req_type,
    output logic                   s_ready,
    input  upcm_pkg::upcm_status_t st,
    output upcm_pkg::upcm_cmd_t    cmd
);

    upcm_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= upcm_pkg::CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = (state_reg == upcm_pkg::CS_IDLE);
        unique case (state_reg)
            upcm_pkg::CS_IDLE: begin
                if (s_valid) begin
                    unique case (s_req_type)
                        upcm_pkg::REQ_TABLE_WR: begin
                            cmd.tbl_write = 1'b1;
                        end
                        upcm_pkg::REQ_CHAR: begin
                            // a character that folds to zero is dropped
                            if (st.char_nonzero) begin
                                cmd.start_char = 1'b1;
                                state_next     = upcm_pkg::CS_SCAN;
                            end
                        end
                        upcm_pkg::REQ_END: begin
                            cmd.start_walk = 1'b1;
                            state_next     = upcm_pkg::CS_WALK;
                        end
                        upcm_pkg::REQ_NONE: begin
                        end
                    endcase
                end
            end
            upcm_pkg::CS_SCAN: begin
                if (st.done) begin
                    state_next = upcm_pkg::CS_IDLE;
                end
            end
            upcm_pkg::CS_WALK: begin
                if (st.done) begin
                    state_next = upcm_pkg::CS_REPORT;
                end
            end
            upcm_pkg::CS_REPORT: begin
                // hold until the output register is free
                if (st.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = upcm_pkg::CS_IDLE;
                end
            end
        endcase
    end

endmodule

// ===== src/upcm_datapath.sv =====
// ----------------------------------------------------------------------------
// upcm_datapath
// Datapath: configuration registers, table memory, verdict memory, the
// pipelined entry sweep and the result register.
// ----------------------------------------------------------------------------
module upcm_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    input  logic [upcm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [upcm_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  upcm_pkg::in_item_t                     s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output upcm_pkg::out_item_t                    m_data,
    input  upcm_pkg::upcm_cmd_t                    cmd,
    output upcm_pkg::upcm_status_t                 st
);

    localparam int IDX_W    = upcm_pkg::IDX_W;
    localparam int CNT_W    = upcm_pkg::CNT_W;
    localparam int POS_W    = upcm_pkg::POS_W;
    localparam int TCHAR_AW = upcm_pkg::TCHAR_AW;
    localparam int CHAR_W   = upcm_pkg::CHAR_W;
    localparam int CMP_W    = upcm_pkg::CMP_W;

    // configuration
    logic                        case_fold_reg;
    logic [upcm_pkg::ECNT_W-1:0] entry_count_reg;

    // memories
    logic [CHAR_W-1:0]   tchar_mem [upcm_pkg::TCHAR_DEPTH];
    upcm_pkg::verdict_t  verd_mem  [upcm_pkg::MAX_ENTRIES];
    logic [upcm_pkg::MAX_ENTRIES-1:0] verd_valid_reg;

    // sweep engine
    logic                run_reg;
    logic                walk_reg;
    logic [CNT_W-1:0]    limit_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [TCHAR_AW-1:0] base_reg;
    logic                p_valid_reg;
    logic [IDX_W-1:0]    p_idx_reg;
    logic                p_vvalid_reg;
    upcm_pkg::verdict_t  verd_rd_reg;
    logic [CHAR_W-1:0]   tchar_rd_reg;
    logic [CHAR_W-1:0]   c1_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [upcm_pkg::HITS_W-1:0] hits_reg;
    logic [IDX_W-1:0]    found_reg;

    // result register
    logic                out_valid_reg;
    upcm_pkg::out_item_t out_data_reg;

    logic                at_end;
    logic                more;
    logic                issue;
    logic                stop_now;
    logic                done;
    logic                verd_we;
    upcm_pkg::verdict_t  verd_wdata;
    upcm_pkg::verdict_t  verd_cur;
    logic [CHAR_W-1:0]   tchar_eff;
    logic [CHAR_W-1:0]   c2;
    logic [CHAR_W-1:0]   c_in_fold;
    logic                tbl_wr_en;
    logic [TCHAR_AW-1:0] wr_addr;
    logic [TCHAR_AW-1:0] rd_addr;
    logic [CMP_W-1:0]    ecnt_ext;
    logic [CNT_W-1:0]    walk_limit;
    logic                hit_open;

    // ------------------------------------------------------------------
    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            case_fold_reg   <= 1'b0;
            entry_count_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == upcm_pkg::CFG_CASE_FOLD) begin
                case_fold_reg <= cfg_data[0];
            end else begin
                entry_count_reg <= upcm_pkg::ECNT_W'(cfg_data);
            end
        end
    end

    // ------------------------------------------------------------------
    // combinational decode
    always_comb begin
        c_in_fold = upcm_pkg::fold_char(case_fold_reg, s_data.char_value);
        tbl_wr_en = cmd.tbl_write
                    && (CMP_W'(s_data.entry_index) < CMP_W'(upcm_pkg::MAX_ENTRIES))
                    && (CMP_W'(s_data.char_pos) < CMP_W'(upcm_pkg::MAX_CHARS));
        wr_addr   = TCHAR_AW'(s_data.entry_index) * TCHAR_AW'(upcm_pkg::MAX_CHARS)
                    + TCHAR_AW'(s_data.char_pos);
        rd_addr   = base_reg + TCHAR_AW'(pos_reg);
        at_end    = (pos_reg == POS_W'(upcm_pkg::MAX_CHARS));

        ecnt_ext  = CMP_W'(entry_count_reg);
        if (ecnt_ext > CMP_W'(upcm_pkg::MAX_ENTRIES)) begin
            walk_limit = CNT_W'(upcm_pkg::MAX_ENTRIES);
        end else begin
            walk_limit = CNT_W'(ecnt_ext);
        end

        verd_cur  = p_vvalid_reg ? verd_rd_reg : upcm_pkg::VERD_OPEN;
        tchar_eff = at_end ? '0 : tchar_rd_reg;
        c2        = upcm_pkg::fold_char(case_fold_reg, tchar_eff);

        verd_we    = 1'b0;
        verd_wdata = upcm_pkg::VERD_OPEN;
        stop_now   = 1'b0;
        hit_open   = 1'b0;
        if (p_valid_reg) begin
            if (walk_reg) begin
                unique case (verd_cur)
                    upcm_pkg::VERD_LESS: begin
                        stop_now = 1'b1;
                    end
                    upcm_pkg::VERD_OPEN: begin
                        hit_open = 1'b1;
                        // exact match ends the walk
                        stop_now = (tchar_eff == '0);
                    end
                    default: begin
                    end
                endcase
            end else if (verd_cur == upcm_pkg::VERD_OPEN && c1_reg != c2) begin
                verd_we    = 1'b1;
                verd_wdata = (c1_reg < c2) ? upcm_pkg::VERD_LESS
                                           : upcm_pkg::VERD_GREATER;
            end
        end

        more  = (idx_reg < limit_reg);
        issue = run_reg && more && !stop_now;
        done  = run_reg && (stop_now || (!more && !p_valid_reg));
    end

    // ------------------------------------------------------------------
    // table memory
    always_ff @(posedge aclk) begin
        if (tbl_wr_en) begin
            tchar_mem[wr_addr] <= s_data.char_value;
        end
        if (issue && !at_end) begin
            tchar_rd_reg <= tchar_mem[rd_addr];
        end
    end

    // verdict memory
    always_ff @(posedge aclk) begin
        if (verd_we) begin
            verd_mem[p_idx_reg] <= verd_wdata;
        end
        if (issue) begin
            verd_rd_reg <= verd_mem[idx_reg[IDX_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // sweep control and per-word state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg        <= 1'b0;
            p_valid_reg    <= 1'b0;
            verd_valid_reg <= '0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.start_char || cmd.start_walk) begin
                run_reg     <= 1'b1;
                p_valid_reg <= 1'b0;
            end else if (run_reg) begin
                p_valid_reg <= issue;
                if (done) begin
                    run_reg <= 1'b0;
                end
            end

            if (verd_we) begin
                verd_valid_reg[p_idx_reg] <= 1'b1;
            end

            // advance the entered position after a character scan
            if (done && !walk_reg && !at_end) begin
                pos_reg <= pos_reg + POS_W'(1);
            end

            if (cmd.load_out) begin
                out_valid_reg  <= 1'b1;
                verd_valid_reg <= '0;
                pos_reg        <= '0;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_char || cmd.start_walk) begin
            walk_reg  <= cmd.start_walk;
            limit_reg <= cmd.start_walk ? walk_limit : CNT_W'(upcm_pkg::MAX_ENTRIES);
            idx_reg   <= '0;
            base_reg  <= '0;
            hits_reg  <= upcm_pkg::HITS_NONE;
            found_reg <= '0;
        end else begin
            if (issue) begin
                idx_reg      <= idx_reg + CNT_W'(1);
                base_reg     <= base_reg + TCHAR_AW'(upcm_pkg::MAX_CHARS);
                p_idx_reg    <= idx_reg[IDX_W-1:0];
                p_vvalid_reg <= verd_valid_reg[idx_reg[IDX_W-1:0]];
            end
            if (hit_open) begin
                found_reg <= p_idx_reg;
                if (hits_reg != upcm_pkg::HITS_MANY) begin
                    hits_reg <= hits_reg + upcm_pkg::HITS_W'(1);
                end
            end
        end
        if (cmd.start_char) begin
            c1_reg <= c_in_fold;
        end
        if (cmd.load_out) begin
            if (hits_reg == upcm_pkg::HITS_NONE) begin
                out_data_reg.match_status <= upcm_pkg::MATCH_NONE;
                out_data_reg.match_index  <= '0;
            end else if (hits_reg == upcm_pkg::HITS_ONE) begin
                out_data_reg.match_status <= upcm_pkg::MATCH_SINGLE;
                out_data_reg.match_index  <= upcm_pkg::OUT_IDX_W'(found_reg);
            end else begin
                out_data_reg.match_status <= upcm_pkg::MATCH_AMBIG;
                out_data_reg.match_index  <= '0;
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_data          = out_data_reg;
    assign st.done         = done;
    assign st.char_nonzero = (c_in_fold != '0);
    assign st.out_free     = !out_valid_reg || m_ready;

    // ------------------------------------------------------------------
    a_pipe_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg |-> run_reg)
        else $error("sweep pipeline holds an entry outside a sweep");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg |-> (idx_reg <= limit_reg))
        else $error("sweep index ran past its limit");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(upcm_pkg::MAX_CHARS))
        else $error("entered position beyond word length");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_ready))
        else $error("result loaded over a pending transaction");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.start_char || cmd.start_walk) |-> !run_reg)
        else $error("sweep started while another is running");

endmodule

// ===== src/unique_prefix_command_matcher.sv =====
// ----------------------------------------------------------------------------
// unique_prefix_command_matcher
// Matches an entered word against a sorted command table by unique prefix.
// ----------------------------------------------------------------------------
// Table write: the input stays ready. Entered character: a sweep of all MAX_ENTRIES entries,
//   one entry per cycle through the registered table and verdict memory reads.
// End of word: a walk over entry_count entries (count capped at MAX_ENTRIES, fewer on an
//   early stop); the result is valid in the same cycle as input ready, later still while
//   the previous result waits on m_ready.
// Synchronous active-low reset clears config, verdicts and position, not the table.
module unique_prefix_command_matcher (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [upcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [upcm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  upcm_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output upcm_pkg::out_item_t             m_data
);

    upcm_pkg::upcm_cmd_t    cmd;
    upcm_pkg::upcm_status_t st;

    assign cfg_ready = 1'b1;

    upcm_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_data.req_type),
        .s_ready    (s_ready),
        .st         (st),
        .cmd        (cmd)
    );

    upcm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the unique-prefix command matcher. Loads sorted
// command tables, enters prefixes, exact, long and noisy words under several
// register settings, and compares every lookup result against a shadow model
// of the table, the per-entry verdicts and the entered position.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_ENTRIES   = upcm_pkg::MAX_ENTRIES;
    localparam int MAX_CHARS     = upcm_pkg::MAX_CHARS;
    localparam int WORD_W        = MAX_CHARS * 8;
    localparam int SETTLE_CYCLES = 2 * MAX_ENTRIES + 16;
    localparam int STALL_LIMIT   = 20000;
    localparam int RX_HOLD       = 1500;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_HIGH    = 8'h80;
    localparam logic [7:0] CH_ALL     = 8'hFF;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [upcm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [upcm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    upcm_pkg::in_item_t              s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    upcm_pkg::out_item_t             m_data;

    // stimulus side
    upcm_pkg::in_item_t  queued_requests[$];
    upcm_pkg::out_item_t expected_matches[$];
    logic [7:0]          word_buf[$];
    logic [WORD_W-1:0]   table_words[MAX_ENTRIES];
    bit                  wide_alpha   = 1'b0;
    bit                  calm         = 1'b0;
    int unsigned         random_items = 0;
    int unsigned         s_offered    = 0;
    int unsigned         s_taken      = 0;
    int unsigned         cfg_taken    = 0;
    int unsigned         rx_hold_req  = 0;
    int unsigned         rx_hold_seen = 0;
    int unsigned         rx_hold_left = 0;
    int unsigned         stall_cycles = 0;

    // shadow of the block
    logic [7:0]          shadow_chars[MAX_ENTRIES][MAX_CHARS];
    upcm_pkg::verdict_t  shadow_verdict[MAX_ENTRIES];
    int unsigned         word_pos    = 0;
    bit                  fold_on     = 1'b0;
    int unsigned         entry_limit = 0;

    // run statistics
    int unsigned error_count = 0;
    int unsigned results_seen = 0;
    int unsigned chars_taken = 0;
    int unsigned writes_taken = 0;

    unique_prefix_command_matcher uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #2 aclk = ~aclk;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        if (fold_on && c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            return c - CASE_BIT;
        end
        return c;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic logic [7:0] char_at(input logic [WORD_W-1:0] w, input int p);
        return w[WORD_W-1-8*p -: 8];
    endfunction

    function automatic int word_len(input logic [WORD_W-1:0] w);
        int n;
        n = 0;
        while (n < MAX_CHARS && char_at(w, n) != CH_NUL) n++;
        return n;
    endfunction

    function automatic logic [7:0] pick_char(input bit wide);
        int unsigned r;
        r = $urandom_range(15);
        if (!wide) return 8'(CH_UPPER_A + $urandom_range(2));
        if (r < 9) return 8'(CH_UPPER_A + $urandom_range(5));
        if (r < 12) return 8'(CH_LOWER_A + $urandom_range(5));
        if (r < 14) return 8'(CH_DIGIT_0 + $urandom_range(9));
        return 8'(CH_HIGH + $urandom_range(127));
    endfunction

    // Work out what one accepted request does to the shadow state.
    task automatic predict_lookup(input upcm_pkg::in_item_t it);
        logic [7:0]          c_in;
        logic [7:0]          c_tbl;
        int                  limit;
        int                  hits;
        int                  found;
        int                  e;
        upcm_pkg::out_item_t res;
        case (it.req_type)
            upcm_pkg::REQ_TABLE_WR: begin
                if (it.char_pos < MAX_CHARS) begin
                    shadow_chars[it.entry_index][it.char_pos] = it.char_value;
                end
            end
            upcm_pkg::REQ_CHAR: begin
                c_in = upcase(it.char_value);
                if (c_in != CH_NUL) begin
                    for (e = 0; e < MAX_ENTRIES; e++) begin
                        if (shadow_verdict[e] == upcm_pkg::VERD_OPEN) begin
                            // past the last column the entry holds an implied zero
                            c_tbl = (word_pos < MAX_CHARS) ? upcase(shadow_chars[e][word_pos])
                                                           : CH_NUL;
                            if (c_in < c_tbl) begin
                                shadow_verdict[e] = upcm_pkg::VERD_LESS;
                            end else if (c_in > c_tbl) begin
                                shadow_verdict[e] = upcm_pkg::VERD_GREATER;
                            end
                        end
                    end
                    if (word_pos < MAX_CHARS) word_pos++;
                end
            end
            upcm_pkg::REQ_END: begin
                limit = (entry_limit > MAX_ENTRIES) ? MAX_ENTRIES : entry_limit;
                hits  = 0;
                found = 0;
                for (e = 0; e < limit; e++) begin
                    if (shadow_verdict[e] == upcm_pkg::VERD_LESS) break;
                    if (shadow_verdict[e] == upcm_pkg::VERD_OPEN) begin
                        hits++;
                        found = e;
                        c_tbl = (word_pos < MAX_CHARS) ? shadow_chars[e][word_pos] : CH_NUL;
                        if (c_tbl == CH_NUL) break;
                    end
                end
                res.match_index = '0;
                if (hits == 0) begin
                    res.match_status = upcm_pkg::MATCH_NONE;
                end else if (hits > 1) begin
                    res.match_status = upcm_pkg::MATCH_AMBIG;
                end else begin
                    res.match_status = upcm_pkg::MATCH_SINGLE;
                    res.match_index  = upcm_pkg::OUT_IDX_W'(found);
                end
                expected_matches.push_back(res);
                for (e = 0; e < MAX_ENTRIES; e++) shadow_verdict[e] = upcm_pkg::VERD_OPEN;
                word_pos = 0;
            end
            default: ;
        endcase
    endtask

    task automatic push_item(input upcm_pkg::req_type_t rt, input logic [5:0] idx,
                             input logic [3:0] pos, input logic [7:0] ch);
        upcm_pkg::in_item_t it;
        it.req_type    = rt;
        it.entry_index = idx;
        it.char_pos    = pos;
        it.char_value  = ch;
        queued_requests.push_back(it);
    endtask

    // Request whose index and position fields carry no meaning.
    task automatic push_req(input upcm_pkg::req_type_t rt, input logic [7:0] ch);
        push_item(rt, 6'($urandom_range(63)), 4'($urandom_range(15)), ch);
    endtask

    task automatic push_noise();
        int unsigned r;
        int unsigned e;
        int unsigned p;
        logic [7:0]  c;
        r = $urandom_range(99);
        if (r < 3) begin
            push_req(upcm_pkg::REQ_CHAR, CH_NUL);
        end else if (r < 5) begin
            push_req(upcm_pkg::REQ_NONE, 8'($urandom_range(255)));
        end else if (r < 7) begin
            e = $urandom_range(MAX_ENTRIES - 1);
            p = $urandom_range(15);
            c = ($urandom_range(1) != 0 && p < MAX_CHARS) ? char_at(table_words[e], p)
                                                         : pick_char(wide_alpha);
            if (p < MAX_CHARS) table_words[e][WORD_W-1-8*p -: 8] = c;
            push_item(upcm_pkg::REQ_TABLE_WR, 6'(e), 4'(p), c);
        end
    endtask

    // Send word_buf as entered characters followed by the closing request.
    task automatic queue_word(input bit noisy);
        int i;
        for (i = 0; i <= word_buf.size(); i++) begin
            if (noisy) push_noise();
            if (i < word_buf.size()) begin
                push_req(upcm_pkg::REQ_CHAR, word_buf[i]);
            end else begin
                push_req(upcm_pkg::REQ_END, 8'($urandom_range(255)));
            end
            random_items++;
        end
    endtask

    task automatic queue_random_word();
        int unsigned kind;
        int unsigned e;
        int unsigned n;
        int unsigned k;
        int unsigned i;
        logic [7:0]  c;
        word_buf.delete();
        kind = $urandom_range(99);
        if (kind < 75) begin
            // prefix of a table word, letters flipped in case now and then
            e = $urandom_range(MAX_ENTRIES - 1);
            n = word_len(table_words[e]);
            k = $urandom_range(n);
            if (k == 0 && n > 0 && $urandom_range(3) != 0) k = n;
            for (i = 0; i < k; i++) begin
                c = char_at(table_words[e], i);
                if (is_letter(c) && $urandom_range(4) == 0) c = c ^ CASE_BIT;
                word_buf.push_back(c);
            end
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 4)) word_buf.push_back(pick_char(wide_alpha));
            end
        end else if (kind < 95) begin
            repeat ($urandom_range(0, 14)) word_buf.push_back(pick_char(wide_alpha));
        end else begin
            repeat ($urandom_range(1, 6)) word_buf.push_back(8'($urandom_range(1, 255)));
        end
        queue_word(1'b1);
    endtask

    task automatic queue_random_items(input int unsigned target);
        int unsigned start;
        start = random_items;
        while (random_items - start < target) queue_random_word();
    endtask

    // Fill all entries with a fresh sorted word list and queue the writes.
    task automatic load_table(input bit wide);
        logic [WORD_W-1:0] w;
        int                e;
        int                p;
        int                n;
        int                j;
        wide_alpha = wide;
        for (e = 0; e < MAX_ENTRIES; e++) begin
            w = '0;
            if (wide) begin
                n = ($urandom_range(7) == 0) ? MAX_CHARS : $urandom_range(1, 6);
            end else begin
                n = $urandom_range(1, 4);
            end
            if (e == 1) n = MAX_CHARS;
            if (wide && e == 0) n = 0;
            for (p = 0; p < n; p++) w[WORD_W-1-8*p -: 8] = pick_char(wide);
            table_words[e] = w;
        end
        for (e = 1; e < MAX_ENTRIES; e++) begin
            w = table_words[e];
            j = e;
            while (j > 0 && table_words[j-1] > w) begin
                table_words[j] = table_words[j-1];
                j--;
            end
            table_words[j] = w;
        end
        for (e = 0; e < MAX_ENTRIES; e++) begin
            for (p = 0; p < MAX_CHARS; p++) begin
                push_item(upcm_pkg::REQ_TABLE_WR, 6'(e), 4'(p), char_at(table_words[e], p));
            end
        end
    endtask

    task automatic write_reg(input logic [upcm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [upcm_pkg::CFG_DATA_W-1:0] val);
        int unsigned target;
        target = cfg_taken + 1;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        while (cfg_taken != target) @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (queued_requests.size() != 0 || s_taken != s_offered ||
               expected_matches.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_taken == s_offered) begin
            if (queued_requests.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
                s_data  <= queued_requests.pop_front();
                s_valid <= 1'b1;
                s_offered++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result ready, with random gaps and an occasional long hold-off
    always @(negedge aclk) begin
        if (rx_hold_req != rx_hold_seen) begin
            rx_hold_seen = rx_hold_req;
            rx_hold_left = RX_HOLD;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 25);
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        upcm_pkg::out_item_t want;
        if (!aresetn) begin
            for (int e = 0; e < MAX_ENTRIES; e++) shadow_verdict[e] = upcm_pkg::VERD_OPEN;
            word_pos    = 0;
            fold_on     = 1'b0;
            entry_limit = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    upcm_pkg::CFG_CASE_FOLD:   fold_on = cfg_data[0];
                    upcm_pkg::CFG_ENTRY_COUNT: entry_limit = 32'(cfg_data);
                    default: ;
                endcase
                cfg_taken++;
            end
            if (s_valid && s_ready) begin
                predict_lookup(s_data);
                if (s_data.req_type == upcm_pkg::REQ_CHAR) chars_taken++;
                if (s_data.req_type == upcm_pkg::REQ_TABLE_WR) writes_taken++;
                s_taken++;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_matches.size() == 0) begin
                    $display("%0t: unexpected result, got status %0d index %0d",
                             $time, m_data.match_status, m_data.match_index);
                    error_count++;
                end else begin
                    want = expected_matches.pop_front();
                    if (m_data.match_status !== want.match_status) begin
                        $display("%0t: match_status expected %0d got %0d",
                                 $time, want.match_status, m_data.match_status);
                        error_count++;
                    end
                    if (m_data.match_index !== want.match_index) begin
                        $display("%0t: match_index expected %0d got %0d",
                                 $time, want.match_index, m_data.match_index);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog: end the run when no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int       e;
        int       i;
        int       n;
        bit       hit;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // narrow alphabet, full table in use
        write_reg(upcm_pkg::CFG_CASE_FOLD, 7'd0);
        write_reg(upcm_pkg::CFG_ENTRY_COUNT, upcm_pkg::CFG_DATA_W'(MAX_ENTRIES));
        load_table(1'b0);
        word_buf.delete();
        queue_word(1'b0);
        push_req(upcm_pkg::REQ_CHAR, CH_UPPER_A);
        push_item(upcm_pkg::REQ_TABLE_WR, 6'd63, 4'd15, CH_ALL);
        push_req(upcm_pkg::REQ_CHAR, CH_NUL);
        push_req(upcm_pkg::REQ_NONE, CH_ALL);
        // rewrite a cell mid-word with its own value
        push_item(upcm_pkg::REQ_TABLE_WR, 6'd63, 4'(MAX_CHARS - 1),
                  char_at(table_words[63], MAX_CHARS - 1));
        push_req(upcm_pkg::REQ_END, CH_NUL);
        queue_random_items(100);
        wait_idle();

        // empty table
        write_reg(upcm_pkg::CFG_ENTRY_COUNT, 7'd0);
        word_buf.delete();
        word_buf.push_back(CH_UPPER_A);
        queue_word(1'b0);
        wait_idle();

        // wide alphabet, folding on, oversized entry count
        write_reg(upcm_pkg::CFG_CASE_FOLD, 7'd1);
        write_reg(upcm_pkg::CFG_ENTRY_COUNT, 7'd127);
        load_table(1'b1);
        word_buf.delete();
        queue_word(1'b0);
        hit = 1'b0;
        for (e = 0; e < MAX_ENTRIES && !hit; e++) begin
            n = word_len(table_words[e]);
            if (n >= 2) begin
                hit = 1'b1;
                word_buf.delete();
                if (n > 3) n = 3;
                for (i = 0; i < n; i++) begin
                    word_buf.push_back(is_letter(char_at(table_words[e], i))
                                       ? (char_at(table_words[e], i) | CASE_BIT)
                                       : char_at(table_words[e], i));
                end
                queue_word(1'b0);
            end
        end
        hit = 1'b0;
        for (e = 0; e < MAX_ENTRIES && !hit; e++) begin
            if (word_len(table_words[e]) == MAX_CHARS) begin
                hit = 1'b1;
                word_buf.delete();
                for (i = 0; i < MAX_CHARS; i++) word_buf.push_back(char_at(table_words[e], i));
                word_buf.push_back(CH_UPPER_Z);
                queue_word(1'b0);
            end
        end
        // hold results back while requests keep coming
        rx_hold_req++;
        queue_random_items(60);
        wait_idle();
        queue_random_items(60);
        wait_idle();

        // single entry
        write_reg(upcm_pkg::CFG_CASE_FOLD, 7'd0);
        write_reg(upcm_pkg::CFG_ENTRY_COUNT, 7'd1);
        queue_random_items(40);
        wait_idle();

        // partial table, first without any idle cycles
        write_reg(upcm_pkg::CFG_CASE_FOLD, 7'd1);
        write_reg(upcm_pkg::CFG_ENTRY_COUNT,
                  upcm_pkg::CFG_DATA_W'($urandom_range(2, MAX_ENTRIES - 1)));
        calm = 1'b1;
        queue_random_items(80);
        wait_idle();
        calm = 1'b0;
        queue_random_items(60);
        wait_idle();

        write_reg(upcm_pkg::CFG_CASE_FOLD, 7'd0);
        write_reg(upcm_pkg::CFG_ENTRY_COUNT, upcm_pkg::CFG_DATA_W'(MAX_ENTRIES));
        queue_random_items(40);
        wait_idle();

        if (expected_matches.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_matches.size());
            error_count += expected_matches.size();
        end
        $display("Checked %0d lookups over %0d entered characters and %0d table writes",
                 results_seen, chars_taken, writes_taken);
        $display("Register writes: %0d, entry counts 0 to 127, case folding on and off",
                 cfg_taken);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
